// ===== src/psu_pkg.sv =====
// Package for the PNG scanline unfilter.
// Holds filter codes, register indexes, size defaults and the Paeth predictor.
// No dependencies.
package psu_pkg;

  localparam int DEF_MAX_ROW_BYTES   = 8192;
  localparam int DEF_MAX_PIXEL_BYTES = 8;

  localparam int BYTE_W    = 8;
  localparam int PIXB_W    = 4;
  localparam int ROWB_W    = 14;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIXEL_BYTES = 1'b0,
    REG_ROW_BYTES   = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    FLT_NONE  = 3'd0,
    FLT_SUB   = 3'd1,
    FLT_UP    = 3'd2,
    FLT_AVG   = 3'd3,
    FLT_PAETH = 3'd4
  } filt_t;

  // a = left, b = up, c = up-left
  function automatic logic [BYTE_W-1:0] paeth(input logic [BYTE_W-1:0] a,
                                              input logic [BYTE_W-1:0] b,
                                              input logic [BYTE_W-1:0] c);
    logic [BYTE_W+1:0] pa;
    logic [BYTE_W+1:0] pb;
    logic [BYTE_W+1:0] pc;
    logic [BYTE_W+1:0] ab;
    logic [BYTE_W+1:0] cc;
    logic [BYTE_W-1:0] sel;
    pa = (b > c) ? {2'b00, b - c} : {2'b00, c - b};
    pb = (a > c) ? {2'b00, a - c} : {2'b00, c - a};
    ab = {2'b00, a} + {2'b00, b};
    cc = {1'b0, c, 1'b0};
    pc = (ab > cc) ? ab - cc : cc - ab;
    if (pa <= pb && pa <= pc) begin
      sel = a;
    end else if (pb <= pc) begin
      sel = b;
    end else begin
      sel = c;
    end
    return sel;
  endfunction

endpackage

// ===== src/png_scanline_unfilter.sv =====
// PNG scanline unfilter: reconstructs filtered scanline bytes (filter method 0).
// Depends on psu_pkg. Holds the previous row in an on-chip line store.
//
// Usage:
//   s_* channel takes the inflated byte stream, one byte per item. s_tuser
//   flags the first byte of an image; the first byte of each scanline is the
//   filter code and produces no output item.
//   m_* channel returns one reconstructed byte per data byte; m_tlast marks
//   the last byte of a scanline.
//   cfg_* channel writes pixel_bytes (index 0) and row_bytes (index 1); it is
//   always ready and must only be used while the block is drained.
// Each result item is registered in stage 1 and then written into the output
//   queue, whose count drives m_tvalid.
// Throughput: 1 item per cycle while s_tready is high; set by the line store,
//   read in the first stage and written back in the second.
// A 4-entry output queue absorbs stalls; s_tready drops once the queue and
//   the item in flight hold three items, so nothing is lost when m_tready is low.
// Reset clears the control state and waits for a filter byte on the first
//   row; the line store is not cleared.
module png_scanline_unfilter #(
  parameter int MAX_ROW_BYTES   = psu_pkg::DEF_MAX_ROW_BYTES,
  parameter int MAX_PIXEL_BYTES = psu_pkg::DEF_MAX_PIXEL_BYTES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [psu_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] in_byte
  input  logic                          s_tuser,   // [0] image_start
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [psu_pkg::BYTE_W-1:0]    m_tdata,   // [7:0] out_byte
  output logic                          m_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [psu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [psu_pkg::ROWB_W-1:0]    cfg_data
);

  localparam int DW = $clog2(MAX_ROW_BYTES);
  localparam int CW = (DW + 1 > psu_pkg::ROWB_W) ? DW + 1 : psu_pkg::ROWB_W;
  localparam int SW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;
  localparam int FIFO_DEPTH = 4;
  localparam int FW = $clog2(FIFO_DEPTH);

  // configuration
  logic [psu_pkg::PIXB_W-1:0] pixel_bytes;
  logic [psu_pkg::ROWB_W-1:0] row_bytes;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_bytes <= psu_pkg::PIXB_W'(1);
      row_bytes   <= psu_pkg::ROWB_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (psu_pkg::cfg_reg_t'(cfg_index))
        psu_pkg::REG_PIXEL_BYTES: pixel_bytes <= cfg_data[psu_pkg::PIXB_W-1:0];
        psu_pkg::REG_ROW_BYTES:   row_bytes   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [psu_pkg::PIXB_W-1:0] stride_eff;
  logic [CW-1:0]              len_eff;
  logic [CW-1:0]              row_ext;

  always_comb begin
    if (pixel_bytes == '0) begin
      stride_eff = psu_pkg::PIXB_W'(1);
    end else if (pixel_bytes > psu_pkg::PIXB_W'(MAX_PIXEL_BYTES)) begin
      stride_eff = psu_pkg::PIXB_W'(MAX_PIXEL_BYTES);
    end else begin
      stride_eff = pixel_bytes;
    end
    row_ext = CW'(row_bytes);
    if (row_bytes == '0) begin
      len_eff = CW'(1);
    end else if (row_ext > CW'(MAX_ROW_BYTES)) begin
      len_eff = CW'(MAX_ROW_BYTES);
    end else begin
      len_eff = row_ext;
    end
  end

  // stage 0: scanline position, filter code, line store read
  logic                 await_filter;
  logic                 first_row;
  psu_pkg::filt_t       filter_kind;
  logic [DW-1:0]        col;
  logic [SW-1:0]        mod_cnt [MAX_PIXEL_BYTES];
  logic                 s_accept;
  logic                 at_filter;
  logic                 row_last;
  logic [psu_pkg::PIXB_W-1:0] slot_sel;
  logic [SW-1:0]        slot_cur;
  logic                 has_left;
  psu_pkg::filt_t       kind_in;

  assign s_accept  = s_tvalid && s_tready;
  assign at_filter = s_tuser || await_filter;
  assign row_last  = (CW'(col) + CW'(1)) >= len_eff;
  assign slot_sel  = stride_eff - psu_pkg::PIXB_W'(1);
  assign slot_cur  = mod_cnt[slot_sel[SW-1:0]];
  assign has_left  = CW'(col) >= CW'(stride_eff);

  always_comb begin
    if (s_tdata inside {[8'd0:8'd4]}) begin
      kind_in = psu_pkg::filt_t'(s_tdata[2:0]);
    end else begin
      kind_in = psu_pkg::FLT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      await_filter <= 1'b1;
      first_row    <= 1'b1;
      filter_kind  <= psu_pkg::FLT_NONE;
      col          <= '0;
      for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
        mod_cnt[k] <= '0;
      end
    end else if (s_accept) begin
      if (at_filter) begin
        await_filter <= 1'b0;
        filter_kind  <= kind_in;
        col          <= '0;
        if (s_tuser) begin
          first_row <= 1'b1;
        end
        for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
          mod_cnt[k] <= '0;
        end
      end else if (row_last) begin
        await_filter <= 1'b1;
        first_row    <= 1'b0;
        col          <= '0;
      end else begin
        col <= col + DW'(1);
        for (int k = 0; k < MAX_PIXEL_BYTES; k++) begin
          mod_cnt[k] <= (mod_cnt[k] == SW'(k)) ? '0 : mod_cnt[k] + SW'(1);
        end
      end
    end
  end

  // stage 1 registers
  logic                       s1_valid;
  logic [psu_pkg::BYTE_W-1:0] s1_byte;
  psu_pkg::filt_t             s1_kind;
  logic [DW-1:0]              s1_col;
  logic [SW-1:0]              s1_slot;
  logic                       s1_has_left;
  logic                       s1_first;
  logic                       s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s_accept && !at_filter;
    end
  end

  always_ff @(posedge clk) begin
    s1_byte     <= s_tdata;
    s1_kind     <= filter_kind;
    s1_col      <= col;
    s1_slot     <= slot_cur;
    s1_has_left <= has_left;
    s1_first    <= first_row;
    s1_last     <= row_last;
  end

  // line store: read in stage 0, written back in stage 1
  logic [psu_pkg::BYTE_W-1:0] prior_row [MAX_ROW_BYTES];
  logic [psu_pkg::BYTE_W-1:0] prior_q;
  logic [psu_pkg::BYTE_W-1:0] res;

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      prior_row[s1_col] <= res;
    end
    prior_q <= prior_row[col];
  end

  // stage 1: prediction
  logic [psu_pkg::BYTE_W-1:0] left_hist   [MAX_PIXEL_BYTES];
  logic [psu_pkg::BYTE_W-1:0] upleft_hist [MAX_PIXEL_BYTES];
  logic [psu_pkg::BYTE_W-1:0] left_b;
  logic [psu_pkg::BYTE_W-1:0] up_b;
  logic [psu_pkg::BYTE_W-1:0] upleft_b;
  logic [psu_pkg::BYTE_W:0]   avg_sum;
  logic [psu_pkg::BYTE_W-1:0] pred;

  always_comb begin
    left_b   = s1_has_left ? left_hist[s1_slot] : '0;
    up_b     = s1_first ? '0 : prior_q;
    upleft_b = (s1_has_left && !s1_first) ? upleft_hist[s1_slot] : '0;
    avg_sum  = {1'b0, left_b} + {1'b0, up_b};
    case (s1_kind)
      psu_pkg::FLT_SUB:   pred = left_b;
      psu_pkg::FLT_UP:    pred = up_b;
      psu_pkg::FLT_AVG:   pred = avg_sum[psu_pkg::BYTE_W:1];
      psu_pkg::FLT_PAETH: pred = psu_pkg::paeth(left_b, up_b, upleft_b);
      default:            pred = '0;
    endcase
    res = s1_byte + pred;
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      left_hist[s1_slot]   <= res;
      upleft_hist[s1_slot] <= up_b;
    end
  end

  // output queue
  logic [psu_pkg::BYTE_W-1:0] q_byte [FIFO_DEPTH];
  logic                       q_last [FIFO_DEPTH];
  logic [FW-1:0]              wr_ptr;
  logic [FW-1:0]              rd_ptr;
  logic [FW:0]                q_count;
  logic                       q_pop;

  assign q_pop    = m_tvalid && m_tready;
  assign m_tvalid = q_count != '0;
  assign m_tdata  = q_byte[rd_ptr];
  assign m_tlast  = q_last[rd_ptr];
  assign s_tready = (q_count + (FW + 1)'(s1_valid)) <= (FW + 1)'(FIFO_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      q_byte[wr_ptr] <= res;
      q_last[wr_ptr] <= s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (s1_valid) begin
        wr_ptr <= wr_ptr + FW'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + FW'(1);
      end
      case ({s1_valid, q_pop})
        2'b10:   q_count <= q_count + (FW + 1)'(1);
        2'b01:   q_count <= q_count - (FW + 1)'(1);
        default: q_count <= q_count;
      endcase
    end
  end

  // checks
  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (q_count < (FW + 1)'(FIFO_DEPTH) || q_pop))
    else $error("output queue overflow");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> q_count != '0)
    else $error("input stalled with empty output queue");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    !await_filter |-> CW'(slot_cur) < CW'(stride_eff))
    else $error("pixel slot outside stride");

  a_first_row_end: assert property (@(posedge clk) disable iff (rst)
    $fell(first_row) |-> $past(s_accept && !at_filter && row_last))
    else $error("first row cleared away from a row end");

endmodule
